>>> hdl/bond_orientational_order_2d_top_defines.svh
// Assertion macros for the bond orientational order block.
`ifndef BOND_ORIENTATIONAL_ORDER_2D_TOP_DEFINES_SVH
`define BOND_ORIENTATIONAL_ORDER_2D_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define BOO_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("boo: property failed");
`define BOO_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("boo: forbidden condition seen");
`else
`define BOO_ASSERT(label, prop)
`define BOO_NEVER(label, cond)
`endif
`endif

>>> hdl/boo_pkg.sv
// Shared types, register codes and tables of the bond orientational order block.
`default_nettype none
package boo_pkg;

  typedef struct packed {
    logic [19:0] pos_x;
    logic [19:0] pos_y;
    logic        type_class;
    logic        excluded;
    logic        frame_end;
  } in_word_t;

  typedef struct packed {
    logic [5:0]         particle_index;
    logic [7:0]         neighbour_count;
    logic signed [15:0] re_first;
    logic signed [15:0] im_first;
    logic [15:0]        mag_first;
    logic signed [15:0] angle_first;
    logic signed [15:0] re_second;
    logic signed [15:0] im_second;
    logic [15:0]        mag_second;
    logic signed [15:0] angle_second;
    logic               last_result;
  } out_word_t;

  // Start request to an iterative unit; alt selects its second operation.
  typedef struct packed {
    logic go;
    logic alt;
  } op_req_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 40;
  localparam int VEC_IN_W = 24;
  localparam int CORDIC_STEPS = 16;
  localparam longint CORDIC_K = 652032874;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIODIC     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_FIRST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_SECOND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_ZZ       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_ZO       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_OO       = 3'd7;

  function automatic logic [15:0] atan_lut(input logic [3:0] idx);
    logic [15:0] v;
    case (idx)
      4'd0:    v = 16'd8192;
      4'd1:    v = 16'd4836;
      4'd2:    v = 16'd2555;
      4'd3:    v = 16'd1297;
      4'd4:    v = 16'd651;
      4'd5:    v = 16'd326;
      4'd6:    v = 16'd163;
      4'd7:    v = 16'd81;
      4'd8:    v = 16'd41;
      4'd9:    v = 16'd20;
      4'd10:   v = 16'd10;
      4'd11:   v = 16'd5;
      4'd12:   v = 16'd3;
      4'd13:   v = 16'd1;
      4'd14:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> hdl/bond_orientational_order_2d_top.sv
// Top level of the 2D bond orientational order (psi_n) block.
//
// Particles arrive one word per accepted start pulse (start high, busy low).
// Up to MAX_PARTICLES words of a frame are stored; later ones are dropped.
// The word with frame_end set starts the frame computation and raises busy.
// Every pair of included particles is tested for a bond; a bonded pair runs
// one CORDIC vectoring, one CORDIC rotation per order and a read-modify-write
// of both particles' accumulators. Then one result word per loaded particle
// is sent in load order, each marked by a single out_valid cycle; a particle
// with neighbours takes two divides, a square root and a CORDIC vectoring
// per order. The CORDIC and divide/root units are shared. last_result marks
// the final word; busy drops in that cycle. The receiver cannot stall.
// Configuration words are written on cfg_we; the user must write them only
// while the block is idle, the block itself does not enforce this.
// Reset restores the register defaults and empties the frame; the sum
// store is never swept, a per-particle valid bit makes stale entries read 0.
`default_nettype none
`include "bond_orientational_order_2d_top_defines.svh"
module bond_orientational_order_2d_top
  import boo_pkg::*;
#(
  parameter int MAX_PARTICLES = 64,
  parameter int NUM_ORDERS    = 2,
  parameter int NUM_TYPES     = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_data,
  output logic                  out_valid,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);
  localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int D_W   = 22;

  typedef struct packed {
    logic [19:0] x;
    logic [19:0] y;
    logic        excl;
    logic        cls;
  } pos_word_t;

  typedef struct packed {
    logic [7:0]         cnt;
    logic signed [23:0] re0;
    logic signed [23:0] im0;
    logic signed [23:0] re1;
    logic signed [23:0] im1;
  } acc_word_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PI_RD, ST_PI_LAT, ST_PJ_RD, ST_PJ_LAT, ST_WRAP_LO, ST_WRAP_HI,
    ST_SQ, ST_CMP, ST_VEC_GO, ST_VEC_WAIT, ST_ROT_GO, ST_ROT_WAIT, ST_ACC_RDI,
    ST_ACC_WRI, ST_ACC_WRJ, ST_NEXT, ST_O_RD, ST_O_LAT, ST_DIV_GO, ST_DIV_WAIT,
    ST_SQM, ST_SQRT_GO, ST_SQRT_WAIT, ST_ANG_GO, ST_ANG_WAIT, ST_EMIT
  } state_t;

  // Configuration registers.
  logic [19:0] box_x_r, box_y_r;
  logic [1:0]  periodic_r;
  logic [3:0]  order_first_r, order_second_r;
  logic [39:0] cut_zz_r, cut_zo_r, cut_oo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r        <= 20'hFFFFF;
      box_y_r        <= 20'hFFFFF;
      periodic_r     <= 2'd3;
      order_first_r  <= 4'd6;
      order_second_r <= 4'd4;
      cut_zz_r       <= '0;
      cut_zo_r       <= '0;
      cut_oo_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_X:        box_x_r        <= cfg_wdata[19:0];
        REG_BOX_Y:        box_y_r        <= cfg_wdata[19:0];
        REG_PERIODIC:     periodic_r     <= cfg_wdata[1:0];
        REG_ORDER_FIRST:  order_first_r  <= cfg_wdata[3:0];
        REG_ORDER_SECOND: order_second_r <= cfg_wdata[3:0];
        REG_CUT_ZZ:       cut_zz_r       <= cfg_wdata[39:0];
        REG_CUT_ZO:       cut_zo_r       <= cfg_wdata[39:0];
        REG_CUT_OO:       cut_oo_r       <= cfg_wdata[39:0];
        default: ;
      endcase
    end
  end

  state_t             state_r;
  logic [CNT_W-1:0]   loaded_r, i_r, j_r, i_nx, j_nx;
  logic               k_r, part_r, out_valid_r, more_k, room, accept;
  logic [MAX_PARTICLES-1:0] acc_valid_r;
  out_word_t          out_r;
  pos_word_t          pi_r, pos_rdata_r, pos_wdata;
  logic               pos_we;
  logic [IDX_W-1:0]   pos_raddr;
  logic               cls_j_r;
  logic signed [D_W-1:0] dx_r, dy_r, lx, ly;
  logic signed [23:0] dx2, dy2;
  logic [43:0]        sqx_r, sqy_r;
  logic [44:0]        r2;
  logic [39:0]        cut;
  logic signed [15:0] theta_r, phi;
  logic [19:0]        phi_prod;
  logic [3:0]         ord_k;
  logic signed [15:0] c_r [2];
  logic signed [15:0] s_r [2];
  logic signed [15:0] re_r [2];
  logic signed [15:0] im_r [2];
  logic [15:0]        mag_r [2];
  logic signed [15:0] ang_r [2];
  logic signed [23:0] sum_re_r [2];
  logic signed [23:0] sum_im_r [2];
  logic [7:0]         cnt_r;
  logic [31:0]        sq_re_r, sq_im_r;

  // Accumulator memory.
  acc_word_t          acc_rdata_r, acc_word, acc_wdata;
  logic               acc_rvalid_r, acc_we;
  logic [IDX_W-1:0]   acc_raddr, acc_waddr;

  // Shared arithmetic units.
  op_req_t            cor_req, ds_req;
  logic               cor_done, ds_done;
  logic signed [VEC_IN_W-1:0] cor_a, cor_b;
  logic signed [15:0] cor_angle, cor_cos, cor_sin;
  logic [31:0]        ds_operand;
  logic [23:0]        ds_result;
  logic signed [23:0] dsum, dabs;
  logic [15:0]        qclamp;
  logic signed [15:0] qsigned;

  assign busy   = state_r != ST_IDLE;
  assign accept = start && (state_r == ST_IDLE);
  assign room   = loaded_r < CNT_W'(MAX_PARTICLES);
  assign i_nx   = i_r + 1'b1;
  assign j_nx   = j_r + 1'b1;
  assign more_k = (k_r == 1'b0) && (NUM_ORDERS > 1);
  assign ord_k  = k_r ? order_second_r : order_first_r;

  always_comb begin
    pos_we          = accept && room;
    pos_wdata.x     = in_data.pos_x;
    pos_wdata.y     = in_data.pos_y;
    pos_wdata.cls   = in_data.type_class;
    pos_wdata.excl  = in_data.excluded || (32'(in_data.type_class) >= NUM_TYPES);
    pos_raddr       = (state_r == ST_PI_RD) ? i_r[IDX_W-1:0] : j_r[IDX_W-1:0];
  end

  pos_word_t pos_mem [MAX_PARTICLES];
  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[loaded_r[IDX_W-1:0]] <= pos_wdata;
    pos_rdata_r <= pos_mem[pos_raddr];
  end

  // Pair geometry.
  always_comb begin
    lx   = $signed({2'b00, box_x_r});
    ly   = $signed({2'b00, box_y_r});
    dx2  = 24'(dx_r) <<< 1;
    dy2  = 24'(dy_r) <<< 1;
    r2   = {1'b0, sqx_r} + {1'b0, sqy_r};
    if (!pi_r.cls && !cls_j_r) cut = cut_zz_r;
    else if (pi_r.cls && cls_j_r) cut = cut_oo_r;
    else cut = cut_zo_r;
    phi_prod = ord_k * theta_r;
    phi      = phi_prod[15:0];
  end

  // Bond update for both ends; the far end takes the sign (-1)^n.
  always_comb begin
    acc_word  = acc_rvalid_r ? acc_rdata_r : '0;
    acc_wdata = acc_word;
    if (acc_word.cnt != 8'hFF) acc_wdata.cnt = acc_word.cnt + 1'b1;
    if (state_r == ST_ACC_WRJ && order_first_r[0]) begin
      acc_wdata.re0 = acc_word.re0 - 24'(c_r[0]);
      acc_wdata.im0 = acc_word.im0 - 24'(s_r[0]);
    end else begin
      acc_wdata.re0 = acc_word.re0 + 24'(c_r[0]);
      acc_wdata.im0 = acc_word.im0 + 24'(s_r[0]);
    end
    if (NUM_ORDERS > 1) begin
      if (state_r == ST_ACC_WRJ && order_second_r[0]) begin
        acc_wdata.re1 = acc_word.re1 - 24'(c_r[1]);
        acc_wdata.im1 = acc_word.im1 - 24'(s_r[1]);
      end else begin
        acc_wdata.re1 = acc_word.re1 + 24'(c_r[1]);
        acc_wdata.im1 = acc_word.im1 + 24'(s_r[1]);
      end
    end
    acc_we    = (state_r == ST_ACC_WRI) || (state_r == ST_ACC_WRJ);
    acc_waddr = (state_r == ST_ACC_WRJ) ? j_r[IDX_W-1:0] : i_r[IDX_W-1:0];
    acc_raddr = (state_r == ST_ACC_WRI) ? j_r[IDX_W-1:0] : i_r[IDX_W-1:0];
  end

  acc_word_t acc_mem [MAX_PARTICLES];
  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    acc_rdata_r  <= acc_mem[acc_raddr];
    acc_rvalid_r <= acc_valid_r[acc_raddr];
  end

  // Unit requests and operands.
  always_comb begin
    cor_req.go  = (state_r == ST_VEC_GO) || (state_r == ST_ROT_GO) ||
                  (state_r == ST_ANG_GO);
    cor_req.alt = state_r == ST_ROT_GO;
    if (state_r == ST_VEC_GO) begin
      cor_a = VEC_IN_W'(dx_r);
      cor_b = VEC_IN_W'(dy_r);
    end else begin
      cor_a = VEC_IN_W'(re_r[k_r]);
      cor_b = VEC_IN_W'(im_r[k_r]);
    end
    ds_req.go  = (state_r == ST_DIV_GO) || (state_r == ST_SQRT_GO);
    ds_req.alt = state_r == ST_SQRT_GO;
    dsum       = part_r ? sum_im_r[k_r] : sum_re_r[k_r];
    dabs       = dsum[23] ? -dsum : dsum;
    // Rounded half away from zero: (|s| + count/2) / count.
    if (state_r == ST_SQRT_GO) ds_operand = sq_re_r + sq_im_r;
    else ds_operand = {8'b0, dabs + {17'b0, cnt_r[7:1]}};
    qclamp  = (ds_result > 24'd32767) ? 16'd32767 : ds_result[15:0];
    qsigned = dsum[23] ? -$signed(qclamp) : $signed(qclamp);
  end

  boo_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (cor_req),
    .in_a   (cor_a),
    .in_b   (cor_b),
    .in_phi (phi),
    .done   (cor_done),
    .angle  (cor_angle),
    .cos_q  (cor_cos),
    .sin_q  (cor_sin)
  );

  boo_divsqrt u_divsqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ds_req),
    .operand (ds_operand),
    .divisor (cnt_r),
    .done    (ds_done),
    .result  (ds_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loaded_r    <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= 1'b0;
      part_r      <= 1'b0;
      out_valid_r <= 1'b0;
      acc_valid_r <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (acc_we) acc_valid_r[acc_waddr] <= 1'b1;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (room) loaded_r <= loaded_r + 1'b1;
            if (in_data.frame_end) begin
              i_r     <= '0;
              state_r <= ST_PI_RD;
            end
          end
        end
        ST_PI_RD: begin
          if (i_r >= loaded_r) begin
            i_r     <= '0;
            state_r <= ST_O_RD;
          end else begin
            state_r <= ST_PI_LAT;
          end
        end
        ST_PI_LAT: begin
          pi_r <= pos_rdata_r;
          if (!pos_rdata_r.excl && (i_nx < loaded_r)) begin
            j_r     <= i_nx;
            state_r <= ST_PJ_RD;
          end else begin
            i_r     <= i_nx;
            state_r <= ST_PI_RD;
          end
        end
        ST_PJ_RD: state_r <= ST_PJ_LAT;
        ST_PJ_LAT: begin
          dx_r    <= $signed({2'b00, pos_rdata_r.x}) - $signed({2'b00, pi_r.x});
          dy_r    <= $signed({2'b00, pos_rdata_r.y}) - $signed({2'b00, pi_r.y});
          cls_j_r <= pos_rdata_r.cls;
          state_r <= pos_rdata_r.excl ? ST_NEXT : ST_WRAP_LO;
        end
        ST_WRAP_LO: begin
          if (periodic_r[0] && (dx2 < -24'(lx))) dx_r <= dx_r + lx;
          if (periodic_r[1] && (dy2 < -24'(ly))) dy_r <= dy_r + ly;
          state_r <= ST_WRAP_HI;
        end
        ST_WRAP_HI: begin
          if (periodic_r[0] && (dx2 > 24'(lx))) dx_r <= dx_r - lx;
          if (periodic_r[1] && (dy2 > 24'(ly))) dy_r <= dy_r - ly;
          state_r <= ST_SQ;
        end
        ST_SQ: begin
          sqx_r   <= 44'(dx_r * dx_r);
          sqy_r   <= 44'(dy_r * dy_r);
          state_r <= ST_CMP;
        end
        ST_CMP: state_r <= (r2 < {5'b0, cut}) ? ST_VEC_GO : ST_NEXT;
        ST_VEC_GO: state_r <= ST_VEC_WAIT;
        ST_VEC_WAIT: begin
          if (cor_done) begin
            theta_r <= cor_angle;
            k_r     <= 1'b0;
            state_r <= ST_ROT_GO;
          end
        end
        ST_ROT_GO: state_r <= ST_ROT_WAIT;
        ST_ROT_WAIT: begin
          if (cor_done) begin
            c_r[k_r] <= cor_cos;
            s_r[k_r] <= cor_sin;
            if (more_k) begin
              k_r     <= 1'b1;
              state_r <= ST_ROT_GO;
            end else begin
              state_r <= ST_ACC_RDI;
            end
          end
        end
        ST_ACC_RDI: state_r <= ST_ACC_WRI;
        ST_ACC_WRI: state_r <= ST_ACC_WRJ;
        ST_ACC_WRJ: state_r <= ST_NEXT;
        ST_NEXT: begin
          if (j_nx < loaded_r) begin
            j_r     <= j_nx;
            state_r <= ST_PJ_RD;
          end else begin
            i_r     <= i_nx;
            state_r <= ST_PI_RD;
          end
        end
        ST_O_RD: state_r <= ST_O_LAT;
        ST_O_LAT: begin
          cnt_r       <= acc_word.cnt;
          sum_re_r[0] <= acc_word.re0;
          sum_im_r[0] <= acc_word.im0;
          sum_re_r[1] <= acc_word.re1;
          sum_im_r[1] <= acc_word.im1;
          for (int n = 0; n < 2; n++) begin
            re_r[n]  <= '0;
            im_r[n]  <= '0;
            mag_r[n] <= '0;
            ang_r[n] <= '0;
          end
          k_r     <= 1'b0;
          part_r  <= 1'b0;
          state_r <= (acc_word.cnt == 8'd0) ? ST_EMIT : ST_DIV_GO;
        end
        ST_DIV_GO: state_r <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (ds_done) begin
            if (part_r) begin
              im_r[k_r] <= qsigned;
              part_r    <= 1'b0;
              state_r   <= ST_SQM;
            end else begin
              re_r[k_r] <= qsigned;
              part_r    <= 1'b1;
              state_r   <= ST_DIV_GO;
            end
          end
        end
        ST_SQM: begin
          sq_re_r <= 32'(re_r[k_r] * re_r[k_r]);
          sq_im_r <= 32'(im_r[k_r] * im_r[k_r]);
          state_r <= ST_SQRT_GO;
        end
        ST_SQRT_GO: state_r <= ST_SQRT_WAIT;
        ST_SQRT_WAIT: begin
          if (ds_done) begin
            mag_r[k_r] <= (ds_result > 24'd32768) ? 16'h8000 : ds_result[15:0];
            state_r    <= ST_ANG_GO;
          end
        end
        ST_ANG_GO: state_r <= ST_ANG_WAIT;
        ST_ANG_WAIT: begin
          if (cor_done) begin
            ang_r[k_r] <= cor_angle;
            if (more_k) begin
              k_r     <= 1'b1;
              state_r <= ST_DIV_GO;
            end else begin
              state_r <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          out_valid_r           <= 1'b1;
          out_r.particle_index  <= 6'(i_r);
          out_r.neighbour_count <= cnt_r;
          out_r.re_first        <= re_r[0];
          out_r.im_first        <= im_r[0];
          out_r.mag_first       <= mag_r[0];
          out_r.angle_first     <= ang_r[0];
          out_r.re_second       <= re_r[1];
          out_r.im_second       <= im_r[1];
          out_r.mag_second      <= mag_r[1];
          out_r.angle_second    <= ang_r[1];
          out_r.last_result     <= i_nx == loaded_r;
          if (i_nx == loaded_r) begin
            loaded_r    <= '0;
            acc_valid_r <= '0;
            state_r     <= ST_IDLE;
          end else begin
            i_r     <= i_nx;
            state_r <= ST_O_RD;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `BOO_ASSERT(a_frame_goes_busy, start && !busy && in_data.frame_end |=> busy)
  `BOO_NEVER(a_pair_distinct, state_r == ST_ACC_WRI && i_r == j_r)
  `BOO_ASSERT(a_load_bound, loaded_r <= CNT_W'(MAX_PARTICLES))
  `BOO_ASSERT(a_last_frees, out_valid && out_data.last_result |-> !busy)

endmodule
`default_nettype wire

>>> hdl/boo_cordic.sv
// Iterative CORDIC unit: vectoring gives an angle, rotation gives Q1.15 cos and sin.
`default_nettype none
module boo_cordic
  import boo_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  op_req_t                    req,
  input  logic signed [VEC_IN_W-1:0] in_a,
  input  logic signed [VEC_IN_W-1:0] in_b,
  input  logic signed [15:0]         in_phi,
  output logic                       done,
  output logic signed [15:0]         angle,
  output logic signed [15:0]         cos_q,
  output logic signed [15:0]         sin_q
);
  localparam int XW = 46;

  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys, a_sc, b_sc, xf, yf;
  logic signed [17:0]   z_r, z_nxt, atan_s, phi_e;
  logic [3:0]           step_r;
  logic                 active_r, done_r, rot_r, zero_r, neg_r, up;

  function automatic logic signed [15:0] q15(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    logic signed [15:0]   r;
    t = (v + XW'(16384)) >>> 15;
    if (t > XW'(32767)) r = 16'sh7FFF;
    else if (t < -XW'(32768)) r = 16'sh8000;
    else r = t[15:0];
    return r;
  endfunction

  always_comb begin
    a_sc   = XW'(in_a) <<< 20;
    b_sc   = XW'(in_b) <<< 20;
    phi_e  = 18'(in_phi);
    xs     = x_r >>> step_r;
    ys     = y_r >>> step_r;
    atan_s = $signed({2'b00, atan_lut(step_r)});
    up     = rot_r ? !z_r[17] : y_r[XW-1];
    if (up) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - atan_s;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + atan_s;
    end
    xf = neg_r ? -x_r : x_r;
    yf = neg_r ? -y_r : y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        active_r <= 1'b1;
        step_r   <= '0;
        rot_r    <= req.alt;
        if (req.alt) begin
          x_r    <= XW'(CORDIC_K);
          y_r    <= '0;
          zero_r <= 1'b0;
          // Fold the angle into the right half plane and flip the result.
          if (phi_e > 18'sd16384) begin
            z_r   <= phi_e - 18'sd32768;
            neg_r <= 1'b1;
          end else if (phi_e < -18'sd16384) begin
            z_r   <= phi_e + 18'sd32768;
            neg_r <= 1'b1;
          end else begin
            z_r   <= phi_e;
            neg_r <= 1'b0;
          end
        end else begin
          zero_r <= (in_a == '0) && (in_b == '0);
          neg_r  <= 1'b0;
          if (in_a[VEC_IN_W-1]) begin
            x_r <= -a_sc;
            y_r <= -b_sc;
            z_r <= 18'sd32768;
          end else begin
            x_r <= a_sc;
            y_r <= b_sc;
            z_r <= '0;
          end
        end
      end else if (active_r) begin
        x_r    <= x_nxt;
        y_r    <= y_nxt;
        z_r    <= z_nxt;
        step_r <= step_r + 1'b1;
        if (step_r == 4'(CORDIC_STEPS - 1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign angle = zero_r ? 16'sd0 : z_r[15:0];
  assign cos_q = q15(xf);
  assign sin_q = q15(yf);

endmodule
`default_nettype wire

>>> hdl/boo_divsqrt.sv
// Bit-serial unit: 24 bit by 8 bit restoring divide, or 32 bit integer square root.
`default_nettype none
module boo_divsqrt
  import boo_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  op_req_t     req,
  input  logic [31:0] operand,
  input  logic [7:0]  divisor,
  output logic        done,
  output logic [23:0] result
);
  logic [31:0] opnd_r;
  logic [19:0] rem_r, rem_sh, trial;
  logic [23:0] res_r;
  logic [7:0]  den_r;
  logic [4:0]  step_r;
  logic        active_r, done_r, sq_r, take;

  always_comb begin
    if (sq_r) begin
      rem_sh = {rem_r[17:0], opnd_r[31:30]};
      trial  = {2'b00, res_r[15:0], 2'b01};
    end else begin
      rem_sh = {11'b0, rem_r[7:0], opnd_r[23]};
      trial  = {12'b0, den_r};
    end
    take = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        active_r <= 1'b1;
        sq_r     <= req.alt;
        opnd_r   <= operand;
        den_r    <= divisor;
        rem_r    <= '0;
        res_r    <= '0;
        step_r   <= '0;
      end else if (active_r) begin
        rem_r  <= take ? rem_sh - trial : rem_sh;
        res_r  <= {res_r[22:0], take};
        opnd_r <= sq_r ? {opnd_r[29:0], 2'b00} : {opnd_r[30:0], 1'b0};
        step_r <= step_r + 1'b1;
        if (step_r == (sq_r ? 5'd15 : 5'd23)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule
`default_nettype wire
